FILE: hw/rtl/bba_pkg.sv
// bba_pkg: shared constants, codes and types of the bitmap block allocator
// no dependencies; used by bba_scan, bitmap_block_allocator, bba_checker and tb_top
package bba_pkg;

  // default geometry of the heap
  localparam int unsigned DEF_BLOCK_COUNT = 4096;
  localparam int unsigned DEF_SEARCH_STEP = 8;
  localparam int unsigned DEF_ALIGN_STEP  = 16;

  // request and result field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned FIRST_W  = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GRANT_W  = 12;

  // stream payload widths; the data widths are padded to whole bytes
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = OPCODE_W;
  localparam int unsigned OUT_DATA_W = 16;

  // bitmap memory word: one bit per block
  localparam int unsigned MAP_W = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC       = 2'd0,
    OP_ALLOC_ALIGN = 2'd1,
    OP_RELEASE     = 2'd2,
    OP_RESERVE     = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_e;

  // control from the sequencer to the run scanner
  typedef struct packed {
    logic init;     // start a new search
    logic vld;      // a bitmap word is on word_i
    logic aligned;  // use the aligned candidate rule
  } scan_ctrl_t;

endpackage

FILE: hw/rtl/bba_ram.sv
// bba_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bba_scan.sv
// bba_scan: free-run scanner, takes one bitmap word per beat from the top down
// depends on bba_pkg
module bba_scan #(
  parameter int unsigned BLOCK_COUNT = bba_pkg::DEF_BLOCK_COUNT,
  parameter int unsigned SEARCH_STEP = bba_pkg::DEF_SEARCH_STEP,
  parameter int unsigned ALIGN_STEP  = bba_pkg::DEF_ALIGN_STEP,
  parameter int unsigned ADDR_W      = $clog2((BLOCK_COUNT + bba_pkg::MAP_W - 1) / bba_pkg::MAP_W),
  parameter int unsigned CW          = ADDR_W + $clog2(bba_pkg::MAP_W) + 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bba_pkg::scan_ctrl_t                   ctrl_i,
  input  logic [ADDR_W-1:0]                     word_addr_i,
  input  logic [bba_pkg::MAP_W-1:0]             word_i,
  input  logic [CW-1:0]                         count_i,
  output logic                                  hit_o,
  output logic [ADDR_W+$clog2(bba_pkg::MAP_W)-1:0] found_o
);
  import bba_pkg::*;

  localparam int unsigned WORDS = (BLOCK_COUNT + MAP_W - 1) / MAP_W;
  localparam int unsigned SEL_W = $clog2(MAP_W);
  localparam int unsigned BIT_W = ADDR_W + SEL_W;
  localparam int unsigned SPH_W = (SEARCH_STEP > 1) ? $clog2(SEARCH_STEP) : 1;
  localparam int unsigned APH_W = (ALIGN_STEP > 1) ? $clog2(ALIGN_STEP) : 1;
  localparam int unsigned TOP   = WORDS * MAP_W - 1;
  localparam int unsigned SPH0  = TOP % SEARCH_STEP;
  localparam int unsigned APH0  = (TOP + 1) % ALIGN_STEP;

  logic [CW-1:0]    run_q, run_d;
  logic [SPH_W-1:0] sph_q, sph_d;   // block index mod SEARCH_STEP
  logic [APH_W-1:0] aph_q, aph_d;   // (block index + 1) mod ALIGN_STEP
  logic             hit_q, hit_d;
  logic [BIT_W-1:0] found_q, found_d;

  // walk the eight bits of the word from high to low, tracking the free run above
  always_comb begin
    logic [BIT_W-1:0] g;
    logic             used;
    logic             cand;
    run_d   = run_q;
    sph_d   = sph_q;
    aph_d   = aph_q;
    hit_d   = hit_q;
    found_d = found_q;
    for (int j = MAP_W - 1; j >= 0; j--) begin
      g     = {word_addr_i, SEL_W'(j)};
      used  = word_i[j] || (CW'(g) >= CW'(BLOCK_COUNT));
      run_d = used ? '0 : run_d + CW'(1);
      cand  = ctrl_i.aligned ? (aph_d == '0) : (sph_d == '0);
      if (cand && (run_d >= count_i)) begin
        hit_d   = 1'b1;
        found_d = g;
      end
      sph_d = (sph_d == '0) ? SPH_W'(SEARCH_STEP - 1) : sph_d - SPH_W'(1);
      aph_d = (aph_d == '0) ? APH_W'(ALIGN_STEP - 1) : aph_d - APH_W'(1);
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      sph_q   <= SPH_W'(SPH0);
      aph_q   <= APH_W'(APH0);
      hit_q   <= 1'b0;
      found_q <= '0;
    end else if (ctrl_i.init) begin
      run_q   <= '0;
      sph_q   <= SPH_W'(SPH0);
      aph_q   <= APH_W'(APH0);
      hit_q   <= 1'b0;
      found_q <= '0;
    end else if (ctrl_i.vld) begin
      run_q   <= run_d;
      sph_q   <= sph_d;
      aph_q   <= aph_d;
      hit_q   <= hit_d;
      found_q <= found_d;
    end
  end

  assign hit_o   = hit_q;
  assign found_o = found_q;

endmodule

FILE: hw/rtl/bitmap_block_allocator.sv
// Bitmap block allocator: one used/free bit per heap block, held in a
// BLOCK_COUNT/8 x 8 ram. After reset a clearing pass writes the ram to all free,
// one word a cycle, and no request is taken until it ends. Each request is one
// beat and gives one result beat. Allocate (first fit on SEARCH_STEP boundaries)
// and aligned allocate (starts at ALIGN_STEP*k-1) always read the whole bitmap
// through one scanner, one word a cycle, then read and write back each bitmap
// word that the granted run touches. Release and reserve read and write back
// each word that they touch. Rejected requests go straight to the result.
// A new request is taken while the previous result still waits.
// depends on bba_pkg, bba_ram, bba_scan
module bitmap_block_allocator #(
  parameter int unsigned BLOCK_COUNT = bba_pkg::DEF_BLOCK_COUNT,
  parameter int unsigned SEARCH_STEP = bba_pkg::DEF_SEARCH_STEP,
  parameter int unsigned ALIGN_STEP  = bba_pkg::DEF_ALIGN_STEP
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request: block_count [12:0], first_block [24:13], zero pad
  input  logic [bba_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // request: opcode [1:0]
  input  logic [bba_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // result: status [1:0], granted_block [13:2], zero pad
  output logic [bba_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);
  import bba_pkg::*;

  localparam int unsigned WORDS  = (BLOCK_COUNT + MAP_W - 1) / MAP_W;
  localparam int unsigned ADDR_W = $clog2(WORDS);
  localparam int unsigned SEL_W  = $clog2(MAP_W);
  localparam int unsigned BIT_W  = ADDR_W + SEL_W;
  localparam int unsigned CW     = (BIT_W + 2 > COUNT_W + 1) ? BIT_W + 2 : COUNT_W + 1;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              issue_q, issue_d;
  logic              vld_q, vld_d;
  logic [ADDR_W-1:0] paddr_q, paddr_d;
  op_e               op_q, op_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     start_q, start_d;
  logic [CW-1:0]     end_q, end_d;
  status_e           status_q, status_d;
  logic [GRANT_W-1:0] grant_q, grant_d;
  logic              m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic              out_load;

  logic              in_acc;
  op_e               op_in;
  logic [CW-1:0]     cnt_in;
  logic [CW-1:0]     first_in;
  logic [CW-1:0]     end_in;
  logic              bad_len;

  logic              ram_we;
  logic [MAP_W-1:0]  ram_wdata;
  logic [MAP_W-1:0]  ram_rdata;
  logic [MAP_W-1:0]  mark_mask;
  logic [CW-1:0]     end_m1;
  logic [ADDR_W-1:0] last_w;

  scan_ctrl_t        scan_ctrl;
  logic              scan_hit;
  logic [BIT_W-1:0]  scan_found;

  // request fields
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign op_in    = op_e'(s_axis_tuser_i[OPCODE_W-1:0]);
  assign cnt_in   = CW'(s_axis_tdata_i[COUNT_W-1:0]);
  assign first_in = CW'(s_axis_tdata_i[COUNT_W +: FIRST_W]);
  assign end_in   = first_in + cnt_in;
  assign bad_len  = (cnt_in == '0) || (cnt_in > CW'(BLOCK_COUNT));

  assign s_axis_tready_o = (state_q == S_IDLE);

  // bits of the current word that fall inside the run being marked
  always_comb begin
    for (int j = 0; j < MAP_W; j++) begin
      mark_mask[j] = (CW'({addr_q, SEL_W'(j)}) >= start_q) &&
                     (CW'({addr_q, SEL_W'(j)}) < end_q);
    end
  end

  assign end_m1 = end_q - CW'(1);
  assign last_w = end_m1[BIT_W-1:SEL_W];

  // sequencer
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    issue_d   = 1'b0;
    vld_d     = 1'b0;
    paddr_d   = paddr_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    start_d   = start_q;
    end_d     = end_q;
    status_d  = status_q;
    grant_d   = grant_q;
    ram_we    = 1'b0;
    ram_wdata = '0;
    scan_ctrl = '{init: 1'b0, vld: 1'b0, aligned: (op_q == OP_ALLOC_ALIGN)};
    out_load  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (addr_q == ADDR_W'(WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          op_d     = op_in;
          cnt_d    = cnt_in;
          grant_d  = '0;
          status_d = ST_OK;
          if (bad_len) begin
            status_d = ST_BAD;
            state_d  = S_DONE;
          end else if (op_in inside {OP_ALLOC, OP_ALLOC_ALIGN}) begin
            scan_ctrl.init = 1'b1;
            addr_d         = ADDR_W'(WORDS - 1);
            issue_d        = 1'b1;
            state_d        = S_SCAN;
          end else if (end_in > CW'(BLOCK_COUNT)) begin
            status_d = ST_BAD;
            state_d  = S_DONE;
          end else begin
            start_d = first_in;
            end_d   = end_in;
            addr_d  = first_in[BIT_W-1:SEL_W];
            state_d = S_MARK_RD;
          end
        end
      end

      // read words top down; the scanner takes each word in the cycle after its read
      S_SCAN: begin
        scan_ctrl.vld = vld_q;
        if (issue_q) begin
          vld_d   = 1'b1;
          paddr_d = addr_q;
          if (addr_q != '0) begin
            issue_d = 1'b1;
            addr_d  = addr_q - ADDR_W'(1);
          end
        end
        if (vld_q && (paddr_q == '0)) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        if (scan_hit) begin
          start_d = CW'(scan_found);
          end_d   = CW'(scan_found) + cnt_q;
          grant_d = GRANT_W'(scan_found);
          addr_d  = scan_found[BIT_W-1:SEL_W];
          state_d = S_MARK_RD;
        end else begin
          status_d = ST_NOFIT;
          state_d  = S_DONE;
        end
      end

      S_MARK_RD: begin
        state_d = S_MARK_WR;
      end

      // read-modify-write of one bitmap word
      S_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (op_q == OP_RELEASE) ? (ram_rdata & ~mark_mask)
                                         : (ram_rdata | mark_mask);
        if (addr_q == last_w) begin
          state_d = S_DONE;
        end else begin
          addr_d  = addr_q + ADDR_W'(1);
          state_d = S_MARK_RD;
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      addr_q    <= '0;
      issue_q   <= 1'b0;
      vld_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      issue_q <= issue_d;
      vld_q   <= vld_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    paddr_q  <= paddr_d;
    op_q     <= op_d;
    cnt_q    <= cnt_d;
    start_q  <= start_d;
    end_q    <= end_d;
    status_q <= status_d;
    grant_q  <= grant_d;
    if (out_load) begin
      m_data_q <= OUT_DATA_W'({grant_q, status_q});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // bitmap storage
  bba_ram #(
    .WIDTH (MAP_W),
    .DEPTH (WORDS),
    .AW    (ADDR_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // shared run scanner
  bba_scan #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .SEARCH_STEP (SEARCH_STEP),
    .ALIGN_STEP  (ALIGN_STEP),
    .ADDR_W      (ADDR_W),
    .CW          (CW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .word_addr_i (paddr_q),
    .word_i      (ram_rdata),
    .count_i     (cnt_q),
    .hit_o       (scan_hit),
    .found_o     (scan_found)
  );

endmodule

FILE: sim/bba_checker.sv
// bba_checker: watches the request and result streams of the bitmap block
// allocator, keeps its own copy of the block bitmap and checks every result beat
// depends on bba_pkg
module bba_checker #(
  parameter int unsigned BLOCK_COUNT = bba_pkg::DEF_BLOCK_COUNT,
  parameter int unsigned SEARCH_STEP = bba_pkg::DEF_SEARCH_STEP,
  parameter int unsigned ALIGN_STEP  = bba_pkg::DEF_ALIGN_STEP
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request: block_count [12:0], first_block [24:13], zero pad
  input  logic [bba_pkg::IN_DATA_W-1:0]  req_tdata_i,
  // request: opcode [1:0]
  input  logic [bba_pkg::IN_USER_W-1:0]  req_tuser_i,
  input  logic                           req_tvalid_i,
  input  logic                           req_tready_i,
  // result: status [1:0], granted_block [13:2], zero pad
  input  logic [bba_pkg::OUT_DATA_W-1:0] res_tdata_i,
  input  logic                           res_tvalid_i,
  input  logic                           res_tready_i,
  output int unsigned                    fail_cnt_o,
  output int unsigned                    pending_cnt_o,
  output int unsigned                    ok_cnt_o,
  output int unsigned                    nofit_cnt_o,
  output int unsigned                    bad_cnt_o
);
  import bba_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [GRANT_W-1:0] granted;
  } outcome_t;

  // one bit per heap block, 1 = used
  logic     heap_used [BLOCK_COUNT];
  outcome_t outcome_q [$];
  outcome_t want;
  status_e  got_status;
  logic [GRANT_W-1:0] got_granted;

  // apply one request to the heap copy and return what the block must answer
  function automatic outcome_t serve_request(op_e op, logic [COUNT_W-1:0] count,
                                             logic [FIRST_W-1:0] first);
    outcome_t    res;
    int unsigned run;
    int unsigned start;
    bit          hit;
    bit          cand;
    res.status  = ST_OK;
    res.granted = '0;
    run   = 0;
    start = 0;
    hit   = 1'b0;
    if (count == 0 || count > BLOCK_COUNT) begin
      res.status = ST_BAD;
    end else if (op inside {OP_ALLOC, OP_ALLOC_ALIGN}) begin
      // walk down from the top so the last hit is the lowest start
      for (int b = BLOCK_COUNT - 1; b >= 0; b--) begin
        run = heap_used[b] ? 0 : run + 1;
        if (op == OP_ALLOC_ALIGN) begin
          cand = ((b + 1) % ALIGN_STEP) == 0;
        end else begin
          cand = (b % SEARCH_STEP) == 0;
        end
        if (cand && run >= count) begin
          start = b;
          hit   = 1'b1;
        end
      end
      if (hit) begin
        for (int unsigned i = 0; i < count; i++) heap_used[start + i] = 1'b1;
        res.granted = start[GRANT_W-1:0];
      end else begin
        res.status = ST_NOFIT;
      end
    end else if (int'(first) + int'(count) > int'(BLOCK_COUNT)) begin
      res.status = ST_BAD;
    end else begin
      for (int unsigned i = 0; i < count; i++) begin
        heap_used[first + i] = (op == OP_RESERVE);
      end
    end
    return res;
  endfunction

  // result beats are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BLOCK_COUNT; i++) heap_used[i] = 1'b0;
      outcome_q.delete();
      fail_cnt_o    = 0;
      pending_cnt_o = 0;
      ok_cnt_o      = 0;
      nofit_cnt_o   = 0;
      bad_cnt_o     = 0;
    end else begin
      if (res_tvalid_i && res_tready_i) begin
        got_status  = status_e'(res_tdata_i[STATUS_W-1:0]);
        got_granted = res_tdata_i[STATUS_W +: GRANT_W];
        case (got_status)
          ST_OK:    ok_cnt_o++;
          ST_NOFIT: nofit_cnt_o++;
          default:  bad_cnt_o++;
        endcase
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d granted %0d",
                   $time, got_status, got_granted);
          fail_cnt_o++;
        end else begin
          want = outcome_q.pop_front();
          if (got_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got_status);
            fail_cnt_o++;
          end
          if (got_granted !== want.granted) begin
            $display("%0t: granted_block mismatch: expected %0d actual %0d",
                     $time, want.granted, got_granted);
            fail_cnt_o++;
          end
        end
      end
      if (req_tvalid_i && req_tready_i) begin
        outcome_q.push_back(serve_request(op_e'(req_tuser_i), req_tdata_i[COUNT_W-1:0],
                                          req_tdata_i[COUNT_W +: FIRST_W]));
      end
      pending_cnt_o = outcome_q.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// tb_top: clock, reset and request stimulus for the bitmap block allocator,
// with random sender bursts and receiver stalls; the verdict comes from bba_checker
// depends on bba_pkg, bitmap_block_allocator, bba_checker
module tb_top;
  import bba_pkg::*;

  localparam int unsigned HEAP_BLOCKS    = DEF_BLOCK_COUNT;
  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser_i  = OP_ALLOC;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned ok_cnt;
  int unsigned nofit_cnt;
  int unsigned bad_cnt;
  int unsigned op_tally [4];
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  bitmap_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  bba_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_tdata_i   (s_axis_tdata_i),
    .req_tuser_i   (s_axis_tuser_i),
    .req_tvalid_i  (s_axis_tvalid_i),
    .req_tready_i  (s_axis_tready_o),
    .res_tdata_i   (m_axis_tdata_o),
    .res_tvalid_i  (m_axis_tvalid_o),
    .res_tready_i  (m_axis_tready_i),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .ok_cnt_o      (ok_cnt),
    .nofit_cnt_o   (nofit_cnt),
    .bad_cnt_o     (bad_cnt)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stalls: always ready, coin flip, or mostly stalled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2);
        mode_left  = $urandom_range(16, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       m_axis_tready_i = 1'b1;
        1:       m_axis_tready_i = 1'($urandom_range(1));
        default: m_axis_tready_i = ($urandom_range(3) == 0);
      endcase
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one request beat, sent in bursts with idle gaps between them
  task automatic send_request(input op_e op, input int unsigned count,
                              input int unsigned first);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = '0;
    s_axis_tdata_i[COUNT_W-1:0]       = count[COUNT_W-1:0];
    s_axis_tdata_i[COUNT_W +: FIRST_W] = first[FIRST_W-1:0];
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    op_tally[op]++;
  endtask

  // mostly short runs, now and then a large one
  function automatic int unsigned run_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 32);
    if (p < 95) return $urandom_range(33, 300);
    return $urandom_range(301, HEAP_BLOCKS);
  endfunction

  task automatic send_random_request();
    int unsigned pick;
    int unsigned first;
    pick  = $urandom_range(99);
    first = $urandom_range(HEAP_BLOCKS - 1);
    if (pick < 40) begin
      send_request(OP_ALLOC, run_length(), first);
    end else if (pick < 55) begin
      send_request(OP_ALLOC_ALIGN, run_length(), first);
    end else if (pick < 78) begin
      send_request(OP_RELEASE, $urandom_range(1, 64), first);
    end else if (pick < 90) begin
      send_request(OP_RESERVE, $urandom_range(1, 48), first);
    end else if (pick < 92) begin
      // free the whole heap so fragmentation starts over
      send_request(OP_RELEASE, HEAP_BLOCKS, 0);
    end else if (pick < 95) begin
      send_request(op_e'($urandom_range(3)), 0, first);
    end else if (pick < 97) begin
      send_request(op_e'($urandom_range(3)), $urandom_range(HEAP_BLOCKS + 1, 8191), first);
    end else begin
      // run that passes the top of the heap
      first = $urandom_range(3000, HEAP_BLOCKS - 1);
      send_request($urandom_range(1) ? OP_RESERVE : OP_RELEASE,
                   HEAP_BLOCKS - first + 1 + $urandom_range(200), first);
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // zero length and oversized requests
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC_ALIGN, 0, 4095);
    send_request(OP_RELEASE, 0, 0);
    send_request(OP_RESERVE, 0, 4095);
    send_request(OP_ALLOC, HEAP_BLOCKS + 1, 0);
    send_request(OP_ALLOC_ALIGN, 8191, 4095);
    // first fit and aligned fit on an empty heap, then a full-size miss
    send_request(OP_ALLOC, 1, 4095);
    send_request(OP_ALLOC_ALIGN, 1, 0);
    send_request(OP_ALLOC, HEAP_BLOCKS, 0);
    // run past the top, and one that ends exactly at the top
    send_request(OP_RELEASE, 2, 4095);
    send_request(OP_RESERVE, 1, 4095);
    send_request(OP_RELEASE, HEAP_BLOCKS, 0);
    // whole heap taken, then nothing fits
    send_request(OP_ALLOC, HEAP_BLOCKS, 0);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC_ALIGN, 1, 0);
    send_request(OP_RELEASE, HEAP_BLOCKS, 0);
    // marking blocks already in the target state, and a hole in a used run
    send_request(OP_RESERVE, 5, 0);
    send_request(OP_RELEASE, 1, 2);
    send_request(OP_RELEASE, 10, 100);
    send_request(OP_RESERVE, 5, 0);
    send_request(OP_ALLOC, 3, 0);
    send_request(OP_ALLOC_ALIGN, 17, 0);
    // aligned run that ends at the top
    send_request(OP_ALLOC_ALIGN, HEAP_BLOCKS - 15, 0);
    send_request(OP_RELEASE, HEAP_BLOCKS, 0);
    send_request(OP_ALLOC_ALIGN, HEAP_BLOCKS - 15, 0);
    send_request(OP_RELEASE, HEAP_BLOCKS, 0);

    repeat (RANDOM_ITEMS) send_random_request();

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("requests: %0d allocate, %0d aligned allocate, %0d release, %0d reserve",
             op_tally[OP_ALLOC], op_tally[OP_ALLOC_ALIGN], op_tally[OP_RELEASE],
             op_tally[OP_RESERVE]);
    $display("results: %0d granted or marked, %0d without a fitting run, %0d rejected",
             ok_cnt, nofit_cnt, bad_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: bitmap_block_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_scan.sv
hw/rtl/bitmap_block_allocator.sv
sim/bba_checker.sv
sim/tb_top.sv
